// File: src/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants, types and state encoding for the combined Tausworthe
// bounded-draw generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t MASK_ONE   = 32'hFFFF_FFFE;
    localparam word_t MASK_TWO   = 32'hFFFF_FFF8;
    localparam word_t MASK_THREE = 32'hFFFF_FFF0;
    localparam word_t MASK_FOUR  = 32'hFFFF_FF80;
    localparam word_t SEED_VALUE = 32'd12345;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    // Controls broadcast to every slice of the remainder chain
    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/combined_tausworthe_random_mod_top.sv
// Bounded draw from a four-component combined Tausworthe generator. Each
// accepted limit advances the generator once and returns the combined word
// modulo the limit; a zero limit returns 0 with m_tuser set. An item is
// loaded into the chain, takes 32 steps of the bit-serial remainder chain
// (one dividend bit per cycle), and its result is then registered when the
// output register is free. The input side is ready again once the result has
// moved to the output register, even while that register waits on m_tready.
// ----------------------------------------------------------------------------
// combined_tausworthe_random_mod_top
// Stream wrapper, sequencing and output register around generator and chain.
// ----------------------------------------------------------------------------
`default_nettype none

module combined_tausworthe_random_mod_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] limit
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic             m_tuser    // [0] limit_was_zero
);
    import tcr_pkg::*;

    state_t state_reg, state_next;
    logic   zero_reg, zero_next;
    logic   out_valid_reg, out_valid_next;
    word_t  out_value_reg;
    logic   out_zero_reg;
    logic   s_fire;
    logic   out_load;
    logic   div_step;
    logic   div_last;
    word_t  word_next;
    word_t  rem;

    assign s_fire = s_tvalid & s_tready;

    tcr_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s_fire),
        .word_next (word_next)
    );

    tcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (s_fire),
        .step  (div_step),
        .word  (word_next),
        .limit (s_tdata),
        .rem   (rem),
        .last  (div_last)
    );

    always_comb
    begin
        state_next     = state_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        div_step       = 1'b0;
        out_load       = 1'b0;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    zero_next  = (s_tdata == '0);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                div_step = 1'b1;
                if (div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= zero_reg ? '0 : rem;
            out_zero_reg  <= zero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_zero_reg;

endmodule

`default_nettype wire

// File: src/tcr_gen.sv
// ----------------------------------------------------------------------------
// tcr_gen
// Four shift-xor components; presents the combined next word and advances
// the components on request.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_gen (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    output tcr_pkg::word_t     word_next
);
    import tcr_pkg::*;

    word_t comp_one_reg,   comp_one_next;
    word_t comp_two_reg,   comp_two_next;
    word_t comp_three_reg, comp_three_next;
    word_t comp_four_reg,  comp_four_next;
    word_t fb_one, fb_two, fb_three, fb_four;

    always_comb
    begin
        fb_one          = ((comp_one_reg << 6) ^ comp_one_reg) >> 13;
        comp_one_next   = ((comp_one_reg & MASK_ONE) << 18) ^ fb_one;

        fb_two          = ((comp_two_reg << 2) ^ comp_two_reg) >> 27;
        comp_two_next   = ((comp_two_reg & MASK_TWO) << 2) ^ fb_two;

        fb_three        = ((comp_three_reg << 13) ^ comp_three_reg) >> 21;
        comp_three_next = ((comp_three_reg & MASK_THREE) << 7) ^ fb_three;

        fb_four         = ((comp_four_reg << 3) ^ comp_four_reg) >> 12;
        comp_four_next  = ((comp_four_reg & MASK_FOUR) << 13) ^ fb_four;
    end

    assign word_next = comp_one_next ^ comp_two_next ^ comp_three_next ^ comp_four_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_one_reg   <= SEED_VALUE;
            comp_two_reg   <= SEED_VALUE;
            comp_three_reg <= SEED_VALUE;
            comp_four_reg  <= SEED_VALUE;
        end
        else if (advance)
        begin
            comp_one_reg   <= comp_one_next;
            comp_two_reg   <= comp_two_next;
            comp_three_reg <= comp_three_next;
            comp_four_reg  <= comp_four_next;
        end
    end

endmodule

`default_nettype wire

// File: src/tcr_cell.sv
// ----------------------------------------------------------------------------
// tcr_cell
// One bit slice of the restoring remainder chain: holds a dividend bit,
// a partial remainder bit and a limit bit, and ripples the borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_cell (
    input  wire logic                clk,
    input  wire tcr_pkg::cell_ctrl_t ctrl,
    input  wire logic                word_bit,
    input  wire logic                lim_bit,
    input  wire logic                div_in,
    input  wire logic                rem_in,
    input  wire logic                borrow_in,
    output logic                     div_out,
    output logic                     rem_out,
    output logic                     borrow_out
);
    import tcr_pkg::*;

    logic div_reg;
    logic rem_reg;
    logic lim_reg;
    logic diff;

    // rem_in is this slice's bit of the shifted remainder
    assign diff       = rem_in ^ lim_reg ^ borrow_in;
    assign borrow_out = (~rem_in & lim_reg) | (~(rem_in ^ lim_reg) & borrow_in);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            div_reg <= word_bit;
            rem_reg <= 1'b0;
            lim_reg <= lim_bit;
        end
        else if (ctrl.step)
        begin
            div_reg <= div_in;
            rem_reg <= ctrl.take ? diff : rem_in;
        end
    end

    assign div_out = div_reg;
    assign rem_out = rem_reg;

endmodule

`default_nettype wire

// File: src/tcr_div.sv
// ----------------------------------------------------------------------------
// tcr_div
// Row of remainder cells with its step counter; one quotient bit per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire logic           step,
    input  wire tcr_pkg::word_t word,
    input  wire tcr_pkg::word_t limit,
    output tcr_pkg::word_t      rem,
    output logic                last
);
    import tcr_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] div_vec;
    logic [WORD_W-1:0] rem_vec;
    logic [WORD_W:0]   borrow;
    cell_ctrl_t        ctrl;

    assign borrow[0] = 1'b0;

    // Subtract fits when the bit shifted out is set or no borrow leaves the row
    always_comb
    begin
        ctrl.load = load;
        ctrl.step = step;
        ctrl.take = rem_vec[WORD_W-1] | ~borrow[WORD_W];
    end

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_cell
        logic div_left;
        logic rem_left;

        if (i == 0)
        begin : g_first
            assign div_left = 1'b0;
            assign rem_left = div_vec[WORD_W-1];
        end
        else
        begin : g_rest
            assign div_left = div_vec[i-1];
            assign rem_left = rem_vec[i-1];
        end

        tcr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .word_bit   (word[i]),
            .lim_bit    (limit[i]),
            .div_in     (div_left),
            .rem_in     (rem_left),
            .borrow_in  (borrow[i]),
            .div_out    (div_vec[i]),
            .rem_out    (rem_vec[i]),
            .borrow_out (borrow[i+1])
        );
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = CNT_W'(WORD_W - 1);
        end
        else if (step)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign last = (cnt_reg == '0);
    assign rem  = rem_vec;

endmodule

`default_nettype wire

// File: src/tcr_chk.sv
// ----------------------------------------------------------------------------
// tcr_chk
// Port-level checks on the bounded-draw generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("zero-limit flag with nonzero value");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a draw is in progress");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##34 m_tvalid)
        else $error("no result 34 cycles after input transaction");

endmodule

bind combined_tausworthe_random_mod_top tcr_chk u_tcr_chk (.*);

`default_nettype wire
